@@ hdl/free_block_bitmap_allocator_top_macros.svh @@
// Assertion macros for the free block bitmap allocator.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FBBA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fbba: assertion failed");
`define FBBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbba: assertion failed");
`else
`define FBBA_ASSERT(lbl, prop)
`define FBBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/fbba_pkg.sv @@
`default_nettype none
package fbba_pkg;
	localparam int BLOCK_COUNT_DEF = 1024;
	localparam int WORD_BITS_DEF = 64;

	localparam int OP_W = 2;
	localparam int BLOCK_W = 10;
	localparam int COUNT_W = 11;

	localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// Blocks 0 and 1 are in use on a freshly formatted disk.
	localparam logic [7:0] RESET_WORD0 = 8'h03;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		logic [BLOCK_W-1:0] block_number;
	} req_item_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] allocated_block;
		logic status;
		logic [COUNT_W-1:0] used_count;
	} rsp_item_t;

	typedef struct packed {
		logic start;
		logic upd;
		logic upd_full;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;
endpackage
`default_nettype wire

@@ hdl/free_block_bitmap_allocator_top.sv @@
// First-fit block allocator over an occupancy bitmap held in a synchronous RAM of
// WORD_BITS-bit words, with one "word full" flag per word kept in flip-flops. After
// reset a clearing pass writes each of the WORD_TOTAL RAM words (16 at the defaults)
// before the first item is taken; blocks 0 and 1 come up in use. An allocate scans the
// full flags in groups of up to 32 words (one group at the defaults) until a free word
// is found, then does a single read-modify-write of the chosen word. One item is in
// work at a time, and the result sits in an output register so the next item can be
// taken while it waits.
`default_nettype none
`include "free_block_bitmap_allocator_top_macros.svh"
module free_block_bitmap_allocator_top #(
	parameter int BLOCK_COUNT = fbba_pkg::BLOCK_COUNT_DEF,
	parameter int WORD_BITS = fbba_pkg::WORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire fbba_pkg::req_item_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output fbba_pkg::rsp_item_t rsp
);
	localparam int WORD_TOTAL = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
	localparam int OFF_W = $clog2(WORD_BITS);
	localparam int BIDX_W = $clog2(BLOCK_COUNT);
	localparam int CNT_W = $clog2(BLOCK_COUNT + 1);
	localparam int BLOCK_W = fbba_pkg::BLOCK_W;
	localparam int EXT_W = ((BIDX_W > BLOCK_W) ? BIDX_W : BLOCK_W) + 1;
	localparam int LAST_BITS = BLOCK_COUNT - (WORD_TOTAL - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam int DIV_SHIFT = BLOCK_W + OFF_W;
	localparam int RECIP_W = 12;
	localparam int PROD_W = BLOCK_W + RECIP_W;
	localparam int RECIP = (2 ** DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_AMOD,
		ST_FRD,
		ST_FMOD,
		ST_RESP
	} state_t;

	state_t state_q;
	logic [WIDX_W-1:0] clr_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [WIDX_W-1:0] q_q;
	logic [OFF_W-1:0] r_q;
	logic [WIDX_W-1:0] w_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BIDX_W-1:0] res_block_q;
	logic res_status_q;
	fbba_pkg::rsp_item_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic in_range;
	logic [PROD_W-1:0] prod;
	logic [WIDX_W-1:0] quot;
	logic [EXT_W-1:0] rem_full;
	logic [WORD_BITS-1:0] vmask;
	logic [WORD_BITS-1:0] avail;
	logic [OFF_W-1:0] apos;
	logic afound;
	logic [WORD_BITS-1:0] aword;
	logic afull;
	logic [BIDX_W-1:0] grant_idx;
	logic fbit;
	logic [WORD_BITS-1:0] fword;

	logic ram_we;
	logic [WIDX_W-1:0] ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WIDX_W-1:0] ram_raddr;
	logic [WORD_BITS-1:0] rdata;

	fbba_pkg::scan_ctl_t scan_ctl;
	fbba_pkg::scan_stat_t scan_stat;
	logic [WIDX_W-1:0] upd_word;
	logic [WIDX_W-1:0] scan_word;

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Word index of a freed block by reciprocal multiplication, exact for 10-bit numbers.
	always_comb begin
		in_range = EXT_W'(req.block_number) < EXT_W'(BLOCK_COUNT);
		prod = PROD_W'(req.block_number) * PROD_W'(RECIP);
		quot = WIDX_W'(prod >> DIV_SHIFT);
		rem_full = EXT_W'(blk_q) - EXT_W'(q_q) * EXT_W'(WORD_BITS);
	end

	always_comb begin
		vmask = (w_q == WIDX_W'(WORD_TOTAL - 1)) ? LAST_MASK : '1;
		avail = rdata | ~vmask;
		apos = '0;
		afound = 1'b0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!avail[i]) begin
				apos = OFF_W'(i);
				afound = 1'b1;
			end
		end
		aword = rdata | (WORD_BITS'(1) << apos);
		afull = &(aword | ~vmask);
		grant_idx = BIDX_W'(EXT_W'(w_q) * EXT_W'(WORD_BITS) + EXT_W'(apos));
		fbit = rdata[r_q];
		fword = rdata & ~(WORD_BITS'(1) << r_q);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = q_q;
		ram_wdata = fword;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0) ? WORD_BITS'(fbba_pkg::RESET_WORD0) : '0;
			end
			ST_AMOD: begin
				ram_we = 1'b1;
				ram_waddr = w_q;
				ram_wdata = aword;
			end
			ST_FMOD: begin
				ram_we = fbit;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_raddr = (state_q == ST_SCAN) ? scan_word : q_q;

		scan_ctl.start = accept && (req.operation == fbba_pkg::OP_ALLOCATE);
		scan_ctl.upd = (state_q == ST_AMOD) || ((state_q == ST_FMOD) && fbit);
		scan_ctl.upd_full = (state_q == ST_AMOD) ? afull : 1'b0;
		upd_word = (state_q == ST_AMOD) ? w_q : q_q;
	end

	fbba_ram #(
		.DEPTH(WORD_TOTAL),
		.WIDTH(WORD_BITS),
		.AW(WIDX_W)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	fbba_summary #(
		.WORD_TOTAL(WORD_TOTAL),
		.WIDX_W(WIDX_W)
	) u_summary (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.upd_word(upd_word),
		.stat(scan_stat),
		.found_word(scan_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			cnt_q <= CNT_W'(2);
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_RESP) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == WIDX_W'(WORD_TOTAL - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						blk_q <= req.block_number;
						q_q <= quot;
						res_block_q <= '0;
						res_status_q <= fbba_pkg::STATUS_OK;
						unique case (req.operation)
							fbba_pkg::OP_ALLOCATE: begin
								state_q <= ST_SCAN;
							end
							fbba_pkg::OP_FREE: begin
								state_q <= in_range ? ST_FRD : ST_RESP;
							end
							fbba_pkg::OP_QUERY: begin
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_stat.done) begin
						if (scan_stat.found) begin
							w_q <= scan_word;
							state_q <= ST_AMOD;
						end else begin
							res_status_q <= fbba_pkg::STATUS_FULL;
							state_q <= ST_RESP;
						end
					end
				end
				ST_AMOD: begin
					cnt_q <= cnt_q + 1'b1;
					res_block_q <= grant_idx;
					state_q <= ST_RESP;
				end
				ST_FRD: begin
					r_q <= OFF_W'(rem_full);
					state_q <= ST_FMOD;
				end
				ST_FMOD: begin
					if (fbit && (cnt_q != '0)) begin
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.allocated_block <= BLOCK_W'(res_block_q);
						rsp_q.status <= res_status_q;
						rsp_q.used_count <= fbba_pkg::COUNT_W'(cnt_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FBBA_ASSERT(a_cnt_range, cnt_q <= CNT_W'(BLOCK_COUNT))
	`FBBA_ASSERT(a_full_cnt, scan_stat.found || !scan_stat.done || cnt_q == CNT_W'(BLOCK_COUNT))
	`FBBA_ASSERT(a_alloc_hit, !(state_q == ST_AMOD) || afound)
	`FBBA_ASSERT_NEXT(a_free_dec, state_q == ST_FMOD && fbit, cnt_q == $past(cnt_q) - 1'b1)
endmodule
`default_nettype wire

@@ hdl/fbba_ram.sv @@
`default_nettype none
module fbba_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	parameter int AW = 4
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ hdl/fbba_summary.sv @@
`default_nettype none
module fbba_summary #(
	parameter int WORD_TOTAL = 16,
	parameter int WIDX_W = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fbba_pkg::scan_ctl_t ctl,
	input wire logic [WIDX_W-1:0] upd_word,
	output fbba_pkg::scan_stat_t stat,
	output logic [WIDX_W-1:0] found_word
);
	localparam int CH_LOG = (WORD_TOTAL >= 32) ? 5 : $clog2(WORD_TOTAL);
	localparam int CH = 2 ** CH_LOG;
	localparam int NCH = (WORD_TOTAL + CH - 1) / CH;
	localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int POS_W = (CH > 1) ? CH_LOG : 1;
	localparam int PAD = NCH * CH;

	logic [WORD_TOTAL-1:0] full_q;
	logic active_q;
	logic [CIDX_W-1:0] chunk_q;

	logic [PAD-1:0] padded;
	logic [CH-1:0] chunk_bits;
	logic hit;
	logic [POS_W-1:0] pos;
	logic last;

	// Padding words past the end read as full so they are never chosen.
	always_comb begin
		padded = '1;
		padded[WORD_TOTAL-1:0] = full_q;
		chunk_bits = padded[int'(chunk_q) * CH +: CH];
		hit = 1'b0;
		pos = '0;
		for (int i = CH - 1; i >= 0; i--) begin
			if (!chunk_bits[i]) begin
				hit = 1'b1;
				pos = POS_W'(i);
			end
		end
		last = (int'(chunk_q) == NCH - 1);
		stat.done = active_q && (hit || last);
		stat.found = active_q && hit;
		found_word = WIDX_W'((int'(chunk_q) << CH_LOG) + int'(pos));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			active_q <= 1'b0;
			chunk_q <= '0;
		end else begin
			if (ctl.upd) begin
				full_q[upd_word] <= ctl.upd_full;
			end
			if (ctl.start) begin
				active_q <= 1'b1;
				chunk_q <= '0;
			end else if (active_q) begin
				if (hit || last) begin
					active_q <= 1'b0;
				end else begin
					chunk_q <= chunk_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ dv/free_block_bitmap_allocator_top_test.sv @@
`default_nettype none
module free_block_bitmap_allocator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fbba_pkg::*;

	localparam int BLOCK_COUNT = BLOCK_COUNT_DEF;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 24;
	localparam int BURST_ITEMS = 120;
	localparam int RANDOM_ITEMS = 300;

	class block_map_tracker;
		bit [BLOCK_COUNT-1:0] shadow_map;
		int unsigned shadow_used;
		rsp_item_t pending_results[$];
		int unsigned mismatches;
		int unsigned requests_seen;
		int unsigned grants_made;
		int unsigned full_refusals;
		int unsigned blocks_released;

		function new();
			shadow_map = '0;
			shadow_map[1:0] = 2'b11;
			shadow_used = 2;
			mismatches = 0;
			requests_seen = 0;
			grants_made = 0;
			full_refusals = 0;
			blocks_released = 0;
		endfunction

		function void note_request(req_item_t item);
			rsp_item_t want;
			int slot;
			int b;
			want = '0;
			want.status = STATUS_OK;
			slot = -1;
			requests_seen++;
			case (item.operation)
			OP_ALLOCATE: begin
				for (b = 0; b < BLOCK_COUNT; b++) begin
					if (!shadow_map[b]) begin
						slot = b;
						break;
					end
				end
				if (slot < 0) begin
					want.status = STATUS_FULL;
					full_refusals++;
				end else begin
					shadow_map[slot] = 1'b1;
					shadow_used++;
					want.allocated_block = BLOCK_W'(slot);
					grants_made++;
				end
			end
			OP_FREE: begin
				if (shadow_map[item.block_number]) begin
					shadow_map[item.block_number] = 1'b0;
					shadow_used--;
					blocks_released++;
				end
			end
			default: begin
			end
			endcase
			want.used_count = COUNT_W'(shadow_used);
			pending_results.push_back(want);
		endfunction

		function void flag(string what, int unsigned want, logic [15:0] got);
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (pending_results.size() == 0) begin
				flag("unexpected result, used_count", 0, 16'(got.used_count));
				return;
			end
			want = pending_results.pop_front();
			if (got.allocated_block !== want.allocated_block)
				flag("allocated_block", want.allocated_block, 16'(got.allocated_block));
			if (got.status !== want.status)
				flag("status", want.status, 16'(got.status));
			if (got.used_count !== want.used_count)
				flag("used_count", want.used_count, 16'(got.used_count));
		endfunction

		function int pick_used_block();
			int start;
			int k;
			int b;
			start = $urandom_range(BLOCK_COUNT - 1);
			for (k = 0; k < BLOCK_COUNT; k++) begin
				b = (start + k) % BLOCK_COUNT;
				if (shadow_map[b])
					return b;
			end
			return start;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_item_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp;

	int req_idle_pct = 34;
	int rsp_idle_pct = 34;
	int quiet_cycles = 0;
	block_map_tracker tracker = new();

	free_block_bitmap_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial rsp_ready = 1'b0;

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			tracker.check_response(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timed out after %0d cycles without a handshake.", quiet_cycles);
			$display("free_block_bitmap_allocator_top_test NOT OK");
			$finish;
		end
	end

	task automatic send_item(req_item_t item);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_request(item);
		@(negedge clk);
	endtask

	task automatic send_op(logic [OP_W-1:0] op, int blk);
		req_item_t item;
		item.operation = op;
		item.block_number = BLOCK_W'(blk);
		send_item(item);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic req_item_t random_request(int alloc_pct, int free_pct);
		req_item_t item;
		int r;
		r = $urandom_range(99);
		item.block_number = BLOCK_W'($urandom_range(BLOCK_COUNT - 1));
		if (r < alloc_pct) begin
			item.operation = OP_ALLOCATE;
		end else if (r < alloc_pct + free_pct) begin
			item.operation = OP_FREE;
			if ($urandom_range(9) < 7)
				item.block_number = BLOCK_W'(tracker.pick_used_block());
		end else if (r < 95) begin
			item.operation = OP_QUERY;
		end else begin
			item.operation = OP_SPARE;
		end
		return item;
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_op(OP_QUERY, 0);
		send_op(OP_SPARE, 1023);
		send_op(OP_ALLOCATE, 1023);
		send_op(OP_ALLOCATE, 0);
		send_op(OP_FREE, 2);
		send_op(OP_FREE, 2);
		send_op(OP_ALLOCATE, 682);
		send_op(OP_FREE, 0);
		send_op(OP_QUERY, 341);
		send_op(OP_ALLOCATE, 0);
		send_op(OP_FREE, 1023);
		send_op(OP_FREE, 1);
		send_op(OP_ALLOCATE, 512);
		send_op(OP_FREE, 512);
		send_op(OP_SPARE, 0);
		drain_results();

		req_idle_pct = 0;
		rsp_idle_pct = 0;
		for (n = 0; n < BURST_ITEMS; n++) begin
			if (n == BURST_ITEMS / 2) begin
				req_idle_pct = 34;
				rsp_idle_pct = 34;
			end
			send_op(OP_ALLOCATE, $urandom_range(BLOCK_COUNT - 1));
		end
		send_op(OP_ALLOCATE, 1023);
		send_op(OP_ALLOCATE, 0);
		send_op(OP_QUERY, 1023);
		send_op(OP_FREE, 1023);
		send_op(OP_ALLOCATE, 5);
		send_op(OP_FREE, 0);
		send_op(OP_ALLOCATE, 1023);
		send_op(OP_FREE, 64);
		send_op(OP_FREE, 63);
		send_op(OP_ALLOCATE, 0);
		send_op(OP_ALLOCATE, 0);
		send_op(OP_ALLOCATE, 0);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			if ((n / 75) % 2 == 0)
				send_item(random_request(20, 60));
			else
				send_item(random_request(60, 20));
		end

		req_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Covered %0d requests: %0d grants, %0d disk-full refusals, %0d releases.",
			tracker.requests_seen, tracker.grants_made, tracker.full_refusals,
			tracker.blocks_released);
		$display("Final used count %0d, %0d mismatches.", tracker.shadow_used,
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("free_block_bitmap_allocator_top_test OK");
		else
			$display("free_block_bitmap_allocator_top_test NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
